>>> hdl/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
// Holds the item structs, opcodes, status codes and controller/datapath links.
// No dependencies.
`default_nettype none

package bdq_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CAP_W = 7;
	localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam logic [1:0] OP_PUSH_LEFT  = 2'd0;
	localparam logic [1:0] OP_PUSH_RIGHT = 2'd1;
	localparam logic [1:0] OP_POP_LEFT   = 2'd2;
	localparam logic [1:0] OP_POP_RIGHT  = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value_out;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic finish_read;
	} dp_cmd_t;

	typedef struct packed {
		logic read_needed;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/bdq_datapath.sv
// Datapath of the bounded deque: element RAM, head, count, capacity, result register.
// Depends on bdq_pkg and bdq_ram.
`default_nettype none

module bdq_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bdq_pkg::in_item_t   in_item,
	input  wire bdq_pkg::dp_cmd_t    cmd,
	output bdq_pkg::dp_stat_t        stat,
	output bdq_pkg::out_item_t       out_item,
	input  wire logic                cfg_we,
	input  wire logic [bdq_pkg::CAP_W-1:0] cfg_wdata
);
	import bdq_pkg::*;

	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [CAP_W-1:0] cap_q;
	out_item_t        out_q;

	logic             is_pop;
	logic             is_full;
	logic             is_empty;
	logic [CMP_W-1:0] eff_cap;
	logic [AW:0]      right_sum;
	logic [AW:0]      last_sum;
	logic [AW-1:0]    right_pos;
	logic [AW-1:0]    last_pos;
	logic [AW-1:0]    left_pos;
	logic [AW-1:0]    next_pos;
	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	logic [31:0]      ram_rdata;

	always_comb begin
		is_pop   = in_item.opcode inside {OP_POP_LEFT, OP_POP_RIGHT};
		eff_cap  = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
		is_full  = CMP_W'(count_q) >= eff_cap;
		is_empty = (count_q == '0);
		stat.read_needed = is_pop && !is_empty;

		// Ring positions: offsets stay below DEPTH, so one subtract wraps them.
		right_sum = {1'b0, head_q} + (AW+1)'(count_q);
		last_sum  = {1'b0, head_q} + (AW+1)'(count_q - 1'b1);
		right_pos = (right_sum >= (AW+1)'(DEPTH)) ?
			AW'(right_sum - (AW+1)'(DEPTH)) : AW'(right_sum);
		last_pos  = (last_sum >= (AW+1)'(DEPTH)) ?
			AW'(last_sum - (AW+1)'(DEPTH)) : AW'(last_sum);
		left_pos  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
		next_pos  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

		case (in_item.opcode)
			OP_PUSH_LEFT:  ram_addr = left_pos;
			OP_PUSH_RIGHT: ram_addr = right_pos;
			OP_POP_LEFT:   ram_addr = head_q;
			OP_POP_RIGHT:  ram_addr = last_pos;
			default:       ram_addr = head_q;
		endcase
		ram_we = cmd.accept && !is_pop && !is_full;
	end

	bdq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (in_item.value_in),
		.re    (cmd.accept && stat.read_needed),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else if (cfg_we) begin
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= cfg_wdata;
		end else if (cmd.accept) begin
			if (!is_pop && !is_full) begin
				count_q <= count_q + 1'b1;
				if (in_item.opcode == OP_PUSH_LEFT) begin
					head_q <= left_pos;
				end
			end else if (is_pop && !is_empty) begin
				count_q <= count_q - 1'b1;
				if (in_item.opcode == OP_POP_LEFT) begin
					head_q <= next_pos;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_read) begin
			out_q.status    <= ST_DONE;
			out_q.value_out <= ram_rdata;
		end else if (cmd.accept) begin
			if (is_pop) begin
				// successful pops are overwritten once the read data lands
				out_q.status    <= ST_EMPTY;
				out_q.value_out <= '0;
			end else if (is_full) begin
				out_q.status    <= ST_FULL;
				out_q.value_out <= '0;
			end else begin
				out_q.status    <= ST_DONE;
				out_q.value_out <= in_item.value_in;
			end
		end
	end

	assign out_item = out_q;

endmodule

`default_nettype wire

>>> hdl/bdq_ctrl.sv
// Controller of the bounded deque: input/output handshake and the read wait state.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire bdq_pkg::dp_stat_t stat,
	output bdq_pkg::dp_cmd_t       cmd
);
	import bdq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	always_comb begin
		// take a new item while idle, once the result slot is free or being drained
		in_ready        = (state_q == S_IDLE) && (!out_valid_q || out_ready);
		accept          = in_valid && in_ready;
		cmd.accept      = accept;
		cmd.finish_read = (state_q == S_READ);
		out_valid       = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (stat.read_needed) begin
							state_q     <= S_READ;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/bounded_double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit values.
// Items enter on in_valid/in_ready carrying an opcode (push left, push right,
// pop left, pop right) and a value; each item yields exactly one result on
// out_valid/out_ready with a status (done, full, empty) and a value.
// Pushes, full pushes and empty pops: result registered in the cycle after the
// item is accepted; a new item may follow in the next cycle.
// Successful pops: the element RAM has a registered read port, so the result
// is registered from the S_READ wait state; the input is held off meanwhile.
// Throughput is one item per cycle unless out_ready stalls or a pop waits on the RAM.
// A single result register sits at the output: a new item is taken while the
// current result is being drained, and the block holds when the receiver stalls.
// cfg_we with cfg_wdata sets the capacity (saturated at 64) and empties the
// queue; write it only while no item is in flight.
// Reset (arst_n low) empties the queue, sets the capacity to 64 and drops
// out_valid. The element RAM is not cleared: entries are read only after a push.
// Depends on bdq_pkg, bdq_ctrl, bdq_datapath and bdq_ram.
`default_nettype none

module bounded_double_ended_queue_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire bdq_pkg::in_item_t        in_item,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output bdq_pkg::out_item_t            out_item,
	input  wire logic                     cfg_we,
	input  wire logic [bdq_pkg::CAP_W-1:0] cfg_wdata
);
	import bdq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bdq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// a successful pop always enters the read wait on the RAM, with the input held off
	a_pop_reads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && stat.read_needed |=> cmd.finish_read && !in_ready)
		else $error("pop did not enter the read wait");

	// read data lands as a done result
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_read |=> out_valid && out_item.status == ST_DONE)
		else $error("read result not presented");

	// items that need no read show their result in the next cycle
	a_direct_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !stat.read_needed |=> out_valid && !cmd.finish_read)
		else $error("direct result missing");

endmodule

`default_nettype wire
